// File: rtl/core/rars_pkg.sv
// ----------------------------------------------------------------------------
// rars_pkg: shared types and constants for the range-add / range-sum tree
// Default tree size, request function codes and the sequencer state type.
// ----------------------------------------------------------------------------
package rars_pkg;

  localparam int DEF_NUM_LEAVES = 1024;
  localparam int POS_W          = 10;
  localparam int DATA_W         = 32;

  // request function codes
  localparam logic FN_ADD = 1'b0;
  localparam logic FN_SUM = 1'b1;

  typedef enum logic [9:0] {
    S_CLR    = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_MUL    = 10'b0000000100,
    S_URD    = 10'b0000001000,
    S_UWR    = 10'b0000010000,
    S_QSTART = 10'b0000100000,
    S_QRD    = 10'b0001000000,
    S_QACC   = 10'b0010000000,
    S_QMUL   = 10'b0100000000,
    S_QFIN   = 10'b1000000000
  } state_t;

endpackage

// File: rtl/core/rars_ram.sv
// ----------------------------------------------------------------------------
// rars_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rars_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/range_add_range_sum_tree_top.sv
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_top: range add / range sum over NUM_LEAVES positions
// Two Fenwick tables with a shared multiplier and a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_func = 0 adds in_add_value to every
//   position in [in_range_lo, in_range_hi]; in_func = 1 requests the sum over
//   that range. Positions past the tree are clipped; an empty range adds
//   nothing and sums to zero. Only sum requests produce an output transaction
//   (out_valid/out_ready, out_range_sum, wrapped 32-bit).
//   One request is in flight at a time; in_ready is high only when idle.
//   Each request walks up to two Fenwick paths, per node a table read, then
//   a write or accumulate, over each table's own read and write ports, plus a
//   multiply per path and, for sums, a start and a finish step per path.
//   Empty ranges and adds of zero finish without leaving the idle state.
//   The result register holds its value while out_ready is low; a finished
//   sum waits for the register to free, and no request is taken meanwhile.
//   After reset the tables are swept to zero, all NUM_LEAVES+1 entries, with
//   in_ready low.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_top
  import rars_pkg::*;
#(
  parameter int NUM_LEAVES = DEF_NUM_LEAVES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_func,
  input  logic [POS_W-1:0]         in_range_lo,
  input  logic [POS_W-1:0]         in_range_hi,
  input  logic signed [DATA_W-1:0] in_add_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_range_sum
);

  localparam int DEPTH = NUM_LEAVES + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = (IW > POS_W) ? IW : POS_W;
  localparam logic [IW:0]   N_IDX = (IW+1)'(NUM_LEAVES);
  localparam logic [CW-1:0] LAST  = CW'(NUM_LEAVES - 1);

  state_t state_r, state_nxt;

  logic [IW-1:0]     l_r, l_nxt;
  logic [IW-1:0]     r_r, r_nxt;
  logic [DATA_W-1:0] v_r, v_nxt;
  logic [IW:0]       idx_r, idx_nxt;
  logic              pass_r, pass_nxt;
  logic [DATA_W-1:0] acc1_r, acc1_nxt;
  logic [DATA_W-1:0] acc2_r, acc2_nxt;
  logic [DATA_W-1:0] p_r, p_nxt;
  logic [DATA_W-1:0] mul_r, mul_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_sum_r, out_sum_nxt;

  logic              we;
  logic [IW-1:0]     waddr;
  logic [DATA_W-1:0] wdata1, wdata2;
  logic [DATA_W-1:0] q1, q2;

  logic [CW-1:0]     lo_c, hi_c, hi_clip;
  logic              rng_ok;
  logic [IW:0]       lowbit, idx_up, idx_dn;
  logic [IW-1:0]     qx;
  logic [DATA_W-1:0] mul_a, mul_b, pfx;
  logic              out_free;

  // two Fenwick tables: positions weight and index-weighted term
  rars_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b1 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata1),
    .raddr(idx_r[IW-1:0]), .rdata(q1)
  );
  rars_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b2 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata2),
    .raddr(idx_r[IW-1:0]), .rdata(q2)
  );

  // decode the request range
  assign lo_c    = CW'(in_range_lo);
  assign hi_c    = CW'(in_range_hi);
  assign hi_clip = (hi_c > LAST) ? LAST : hi_c;
  assign rng_ok  = (hi_c >= lo_c) && (lo_c <= LAST);

  // index stepping along a Fenwick path
  assign lowbit = idx_r & (~idx_r + (IW+1)'(1));
  assign idx_up = idx_r + lowbit;
  assign idx_dn = idx_r - lowbit;

  // prefix end for the current query pass
  assign qx = pass_r ? (l_r - IW'(1)) : r_r;

  // shared multiplier operand select
  always_comb begin
    if (state_r == S_MUL) begin
      mul_a = v_r;
      mul_b = pass_r ? DATA_W'(r_r) : DATA_W'(l_r - IW'(1));
    end else begin
      mul_a = acc1_r;
      mul_b = DATA_W'(qx);
    end
  end

  assign pfx      = mul_r - acc2_r;
  assign out_free = !out_valid_r || out_ready;

  // table write port: clear sweep or update
  always_comb begin
    we     = 1'b0;
    waddr  = idx_r[IW-1:0];
    wdata1 = q1 + (pass_r ? (~v_r + DATA_W'(1)) : v_r);
    wdata2 = q2 + (pass_r ? (~mul_r + DATA_W'(1)) : mul_r);
    if (state_r == S_CLR) begin
      we     = 1'b1;
      wdata1 = '0;
      wdata2 = '0;
    end else if (state_r == S_UWR) begin
      we = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    v_nxt         = v_r;
    idx_nxt       = idx_r;
    pass_nxt      = pass_r;
    acc1_nxt      = acc1_r;
    acc2_nxt      = acc2_r;
    p_nxt         = p_r;
    mul_nxt       = mul_r;
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        idx_nxt = idx_r + (IW+1)'(1);
        if (idx_r == N_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && out_free) begin
          l_nxt    = IW'(lo_c) + IW'(1);
          r_nxt    = IW'(hi_clip) + IW'(1);
          v_nxt    = in_add_value;
          pass_nxt = 1'b0;
          if (in_func == FN_ADD) begin
            if (rng_ok && (in_add_value != '0)) begin
              idx_nxt   = (IW+1)'(IW'(lo_c) + IW'(1));
              state_nxt = S_MUL;
            end
          end else if (rng_ok) begin
            state_nxt = S_QSTART;
          end else begin
            out_valid_nxt = 1'b1;
            out_sum_nxt   = '0;
          end
        end
      end
      S_MUL: begin
        mul_nxt   = mul_a * mul_b;
        state_nxt = S_URD;
      end
      S_URD: begin
        state_nxt = S_UWR;
      end
      S_UWR: begin
        idx_nxt = idx_up;
        if (idx_up > N_IDX) begin
          if (!pass_r && (r_r != IW'(NUM_LEAVES))) begin
            pass_nxt  = 1'b1;
            idx_nxt   = (IW+1)'(r_r) + (IW+1)'(1);
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_URD;
        end
      end
      S_QSTART: begin
        idx_nxt  = (IW+1)'(qx);
        acc1_nxt = '0;
        acc2_nxt = '0;
        state_nxt = (qx == '0) ? S_QMUL : S_QRD;
      end
      S_QRD: begin
        state_nxt = S_QACC;
      end
      S_QACC: begin
        acc1_nxt = acc1_r + q1;
        acc2_nxt = acc2_r + q2;
        idx_nxt  = idx_dn;
        state_nxt = (idx_dn == '0) ? S_QMUL : S_QRD;
      end
      S_QMUL: begin
        mul_nxt   = mul_a * mul_b;
        state_nxt = S_QFIN;
      end
      S_QFIN: begin
        if (!pass_r) begin
          p_nxt     = pfx;
          pass_nxt  = 1'b1;
          state_nxt = S_QSTART;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = p_r - pfx;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold control state under reset, advance otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    v_r       <= v_nxt;
    acc1_r    <= acc1_nxt;
    acc2_r    <= acc2_nxt;
    p_r       <= p_nxt;
    mul_r     <= mul_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign in_ready      = (state_r == S_IDLE) && out_free;
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

endmodule
